>>> rtl/core/ps2_mouse_cursor_tracker_core_macros.svh
// Assertion macros for the PS/2 mouse cursor tracker.
// Depends on nothing; included by files that check their own logic.
`ifndef PS2_MOUSE_CURSOR_TRACKER_CORE_MACROS_SVH
`define PS2_MOUSE_CURSOR_TRACKER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, quiet while reset is high.
`define PMCT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pmct assertion failed");
// Next-cycle implication, quiet while reset is high.
`define PMCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pmct assertion failed");
`else
`define PMCT_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define PMCT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/pmct_pkg.sv
// Shared widths, constants and types of the PS/2 mouse cursor tracker.
// Used by the interfaces, the serial units and the top level.
package pmct_pkg;

  localparam int BYTE_W     = 8;
  localparam int COORD_W    = 13;
  localparam int LIN_W      = 25;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int DIV_W      = 8;

  // Largest coordinate any axis may reach, whatever the bound registers say.
  localparam int COORD_MAX = 4096;
  localparam logic [COORD_W-1:0] COORD_LIMIT = COORD_W'(COORD_MAX);

  // Register values after reset.
  localparam logic [COORD_W-1:0] WIDTH_RESET  = COORD_W'(1024);
  localparam logic [COORD_W-1:0] HEIGHT_RESET = COORD_W'(768);
  localparam logic [DIV_W-1:0]   SPEED_RESET  = DIV_W'(1);

  // Status byte overflow flags.
  localparam int STATUS_X_OVF_BIT = 6;
  localparam int STATUS_Y_OVF_BIT = 7;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH,
    CFG_SCREEN_HEIGHT,
    CFG_SPEED_DIVISOR
  } cfg_reg_t;

  // Position of the next byte inside a packet.
  typedef enum logic [1:0] {
    PH_STATUS,
    PH_DX,
    PH_DY
  } phase_t;

  // Packet sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_MUL,
    ST_OUT
  } state_t;

endpackage

>>> rtl/core/pmct_if.sv
// Valid/ready channels of the PS/2 mouse cursor tracker: mouse bytes in,
// cursor results out. Depends on pmct_pkg for field widths.
interface pmct_byte_if;
  logic                           valid;
  logic                           ready;
  logic [pmct_pkg::BYTE_W-1:0]    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pmct_cursor_if;
  logic                           valid;
  logic                           ready;
  logic [pmct_pkg::BYTE_W-1:0]    button_status;
  logic [pmct_pkg::COORD_W-1:0]   cursor_x;
  logic [pmct_pkg::COORD_W-1:0]   cursor_y;
  logic [pmct_pkg::LIN_W-1:0]     linear_position;

  modport source (output valid, output button_status, output cursor_x,
                  output cursor_y, output linear_position, input ready);
  modport sink   (input valid, input button_status, input cursor_x,
                  input cursor_y, input linear_position, output ready);
endinterface

>>> rtl/core/pmct_div.sv
// Bit-serial restoring divider for delta magnitudes, one quotient bit a cycle.
// Depends on pmct_pkg for the operand width.
module pmct_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pmct_pkg::DIV_W-1:0]   dividend,
  input  logic [pmct_pkg::DIV_W-1:0]   divisor,
  output logic                         done,
  output logic [pmct_pkg::DIV_W-1:0]   quotient
);

  localparam int W  = pmct_pkg::DIV_W;
  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] count;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvsr;
  logic [W:0]    shifted;
  logic [W+1:0]  diff;
  logic          borrow;

  // One trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    shifted = {rem, quo[W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvsr};
    borrow  = diff[W+1];
  end

  // Control: a start loads the operands, then W steps run.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CW'(1);
        if (count == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out of quo while quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= borrow ? shifted[W-1:0] : diff[W-1:0];
      quo <= {quo[W-2:0], ~borrow};
    end
  end

  assign quotient = quo;

endmodule

>>> rtl/core/pmct_mult.sv
// Shift-add multiplier that forms addend + multiplicand * multiplier,
// one multiplier bit a cycle. Depends on pmct_pkg for widths.
module pmct_mult (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pmct_pkg::COORD_W-1:0]   multiplicand,
  input  logic [pmct_pkg::COORD_W-1:0]   multiplier,
  input  logic [pmct_pkg::COORD_W-1:0]   addend,
  output logic                           done,
  output logic [pmct_pkg::LIN_W-1:0]     product
);

  localparam int CW_IN = pmct_pkg::COORD_W;
  localparam int PW    = pmct_pkg::LIN_W;
  localparam int CW    = $clog2(CW_IN);

  logic          busy;
  logic [CW-1:0] count;
  logic [PW-1:0] acc;
  logic [PW-1:0] mcand;
  logic [CW_IN-1:0] mplier;

  // Control: one step per multiplier bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CW'(1);
        if (count == CW'(CW_IN - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the accumulator starts at the addend; products wrap to PW bits.
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= PW'(addend);
      mcand  <= PW'(multiplicand);
      mplier <= multiplier;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[PW-2:0], 1'b0};
      mplier <= {1'b0, mplier[CW_IN-1:1]};
    end
  end

  assign product = acc;

endmodule

>>> rtl/core/ps2_mouse_cursor_tracker_core.sv
// Top level of the PS/2 mouse cursor tracker: packet framing, cursor update
// and result buffer. Depends on pmct_pkg, pmct_if, pmct_div and pmct_mult.
//
// The block drops the first mouse byte after reset, then groups bytes into
// status, dx, dy packets and sends one cursor item per packet. Status and dx
// bytes are taken whenever the sequencer is idle. A dy byte starts the
// packet update: the shared bit-serial divider scales dx and then dy (each
// axis applied as its quotient is ready), and the shift-add multiplier forms
// the linear position. The ST_OUT state then loads the output register and
// returns the sequencer to idle; no further byte is taken before that. The
// result sits in an output register, so bytes of the next packet are taken
// while it waits to be read. If that register still holds an unread item
// when the next result is ready, the sequencer waits and the input stalls.
// A speed divisor of zero acts as one; bounds above COORD_MAX are limited to it.
module ps2_mouse_cursor_tracker_core (
  input  logic                                clk,
  input  logic                                rst,
  pmct_byte_if.sink                           byte_ch,
  pmct_cursor_if.source                       cursor_ch,
  input  logic                                cfg_we,
  input  logic [pmct_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pmct_pkg::CFG_DATA_W-1:0]     cfg_data
);

  `include "ps2_mouse_cursor_tracker_core_macros.svh"

  localparam int BW = pmct_pkg::BYTE_W;
  localparam int CW = pmct_pkg::COORD_W;
  localparam int SW = pmct_pkg::COORD_W + 2;

  // Configuration registers.
  logic [CW-1:0]               screen_width;
  logic [CW-1:0]               screen_height;
  logic [pmct_pkg::DIV_W-1:0]  speed_divisor;

  // Packet state.
  pmct_pkg::state_t state, state_next;
  pmct_pkg::phase_t phase;
  logic             skip_first;
  logic [BW-1:0]    held_status;
  logic [BW-1:0]    held_dx;
  logic [BW-1:0]    held_dy;
  logic [CW-1:0]    pos_x;
  logic [CW-1:0]    pos_y;

  // Handshake and unit control.
  logic byte_take;
  logic packet_end;
  logic div_start;
  logic div_done;
  logic mul_start;
  logic mul_done;
  logic out_load;

  logic [pmct_pkg::DIV_W-1:0]  div_a;
  logic [pmct_pkg::DIV_W-1:0]  div_d;
  logic [pmct_pkg::DIV_W-1:0]  div_q;
  logic [pmct_pkg::LIN_W-1:0]  product;

  logic [CW-1:0]        wb;
  logic [CW-1:0]        hb;
  logic signed [SW-1:0] step;
  logic signed [SW-1:0] nx;
  logic signed [SW-1:0] ny;
  logic [CW-1:0]        x_new;
  logic [CW-1:0]        y_new;

  // Magnitude of a two's complement byte; the most negative byte gives 128.
  function automatic logic [BW-1:0] mag(input logic [BW-1:0] b);
    mag = b[BW-1] ? (~b + BW'(1)) : b;
  endfunction

  // Clamp a signed coordinate to 0..bound.
  function automatic logic [CW-1:0] clamp(input logic signed [SW-1:0] v,
                                          input logic [CW-1:0] bound);
    logic [CW-1:0] r;
    if (v[SW-1]) begin
      r = '0;
    end else if (v[SW-2:0] > {1'b0, bound}) begin
      r = bound;
    end else begin
      r = v[CW-1:0];
    end
    clamp = r;
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= pmct_pkg::WIDTH_RESET;
      screen_height <= pmct_pkg::HEIGHT_RESET;
      speed_divisor <= pmct_pkg::SPEED_RESET;
    end else if (cfg_we) begin
      unique case (pmct_pkg::cfg_reg_t'(cfg_index))
        pmct_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        pmct_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        pmct_pkg::CFG_SPEED_DIVISOR: speed_divisor <= cfg_data[pmct_pkg::DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective bounds and divisor.
  always_comb begin
    wb    = (screen_width  > pmct_pkg::COORD_LIMIT) ? pmct_pkg::COORD_LIMIT : screen_width;
    hb    = (screen_height > pmct_pkg::COORD_LIMIT) ? pmct_pkg::COORD_LIMIT : screen_height;
    div_d = (speed_divisor == '0) ? pmct_pkg::DIV_W'(1) : speed_divisor;
  end

  // Scaled delta of the axis being finished, and the new clamped positions.
  always_comb begin
    logic sign_bit;
    sign_bit = (state == pmct_pkg::ST_DIV_X) ? held_dx[BW-1] : held_dy[BW-1];
    step  = sign_bit ? -$signed(SW'(div_q)) : $signed(SW'(div_q));
    nx    = $signed(SW'(pos_x));
    if (!held_status[pmct_pkg::STATUS_X_OVF_BIT]) begin
      nx = nx + step;
    end
    ny    = $signed(SW'(pos_y));
    if (!held_status[pmct_pkg::STATUS_Y_OVF_BIT]) begin
      ny = ny - step;
    end
    x_new = clamp(nx, wb);
    y_new = clamp(ny, hb);
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit control.
  always_comb begin
    state_next     = state;
    byte_ch.ready  = 1'b0;
    div_start      = 1'b0;
    mul_start      = 1'b0;
    out_load       = 1'b0;
    div_a          = mag(held_dx);
    byte_take      = byte_ch.valid && (state == pmct_pkg::ST_IDLE);
    packet_end     = byte_take && !skip_first && (phase == pmct_pkg::PH_DY);
    unique case (state)
      pmct_pkg::ST_IDLE: begin
        byte_ch.ready = 1'b1;
        if (packet_end) begin
          div_start  = 1'b1;
          state_next = pmct_pkg::ST_DIV_X;
        end
      end
      pmct_pkg::ST_DIV_X: begin
        div_a = mag(held_dy);
        if (div_done) begin
          div_start  = 1'b1;
          state_next = pmct_pkg::ST_DIV_Y;
        end
      end
      pmct_pkg::ST_DIV_Y: begin
        if (div_done) begin
          mul_start  = 1'b1;
          state_next = pmct_pkg::ST_MUL;
        end
      end
      pmct_pkg::ST_MUL: begin
        if (mul_done) begin
          state_next = pmct_pkg::ST_OUT;
        end
      end
      pmct_pkg::ST_OUT: begin
        if (!cursor_ch.valid || cursor_ch.ready) begin
          out_load   = 1'b1;
          state_next = pmct_pkg::ST_IDLE;
        end
      end
      default: state_next = pmct_pkg::ST_IDLE;
    endcase
  end

  // Byte framing control and cursor position updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_first <= 1'b1;
      phase      <= pmct_pkg::PH_STATUS;
      pos_x      <= '0;
      pos_y      <= '0;
    end else begin
      if (byte_take) begin
        if (skip_first) begin
          skip_first <= 1'b0;
        end else begin
          unique case (phase)
            pmct_pkg::PH_DX: phase <= pmct_pkg::PH_DY;
            pmct_pkg::PH_DY: phase <= pmct_pkg::PH_STATUS;
            default:         phase <= pmct_pkg::PH_DX;
          endcase
        end
      end
      if (state == pmct_pkg::ST_DIV_X && div_done) begin
        pos_x <= x_new;
      end
      if (state == pmct_pkg::ST_DIV_Y && div_done) begin
        pos_y <= y_new;
      end
    end
  end

  // Held packet bytes.
  always_ff @(posedge clk) begin
    if (byte_take && !skip_first) begin
      unique case (phase)
        pmct_pkg::PH_DX: held_dx     <= byte_ch.rx_byte;
        pmct_pkg::PH_DY: held_dy     <= byte_ch.rx_byte;
        default:         held_status <= byte_ch.rx_byte;
      endcase
    end
  end

  // Shared delta divider.
  pmct_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // Linear position: pos_x + screen_width * pos_y.
  pmct_mult u_mult (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (screen_width),
    .multiplier   (y_new),
    .addend       (pos_x),
    .done         (mul_done),
    .product      (product)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_ch.valid <= 1'b0;
    end else if (out_load) begin
      cursor_ch.valid <= 1'b1;
    end else if (cursor_ch.ready) begin
      cursor_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cursor_ch.button_status   <= held_status;
      cursor_ch.cursor_x        <= pos_x;
      cursor_ch.cursor_y        <= pos_y;
      cursor_ch.linear_position <= product;
    end
  end

  // Checks on the sequencer.
  `PMCT_ASSERT_NEXT(a_packet_starts_div, clk, rst, packet_end, state == pmct_pkg::ST_DIV_X)
  `PMCT_ASSERT_IMPLIES(a_div_done_in_div, clk, rst, div_done, state == pmct_pkg::ST_DIV_X || state == pmct_pkg::ST_DIV_Y)
  `PMCT_ASSERT_IMPLIES(a_mul_done_in_mul, clk, rst, mul_done, state == pmct_pkg::ST_MUL)
  `PMCT_ASSERT_IMPLIES(a_result_from_out, clk, rst, $rose(cursor_ch.valid), $past(state) == pmct_pkg::ST_OUT)

endmodule

>>> tb/tb.sv
// Self-checking testbench for ps2_mouse_cursor_tracker_core: drives mouse bytes
// and register writes, predicts each cursor item and checks it on arrival.
// Depends on pmct_pkg, pmct_if and the core RTL.
module tb;
  import pmct_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 48;
  localparam int DRAIN_CYCLES  = 64;

  typedef struct {
    logic [BYTE_W-1:0]  status;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LIN_W-1:0]   lin;
  } cursor_item_t;

  // Cursor tracking model and queue of cursor items still to arrive.
  class cursor_tracker_sb;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [DIV_W-1:0]      speed_reg;
    bit                    drop_next;
    phase_t                next_phase;
    logic [BYTE_W-1:0]     held_status;
    logic [BYTE_W-1:0]     held_dx;
    int                    pos_x;
    int                    pos_y;
    cursor_item_t          awaited[$];
    int                    errors;

    function new();
      width_reg   = WIDTH_RESET;
      height_reg  = HEIGHT_RESET;
      speed_reg   = SPEED_RESET;
      drop_next   = 1'b1;
      next_phase  = PH_STATUS;
      held_status = '0;
      held_dx     = '0;
      pos_x       = 0;
      pos_y       = 0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SCREEN_WIDTH:  width_reg = data;
        CFG_SCREEN_HEIGHT: height_reg = data;
        CFG_SPEED_DIVISOR: speed_reg = data[DIV_W-1:0];
        default: ;
      endcase
    endfunction

    // Clamp one axis to 0..bound.
    function int clamp_axis(int v, int bound);
      if (v < 0) return 0;
      if (v > bound) return bound;
      return v;
    endfunction

    // Advance the packet framing by one accepted byte.
    function void note_byte(logic [BYTE_W-1:0] b);
      int div_eff, wb, hb, nx, ny, step_x, step_y;
      longint lin_full;
      cursor_item_t item;
      if (drop_next) begin
        drop_next = 1'b0;
        return;
      end
      case (next_phase)
        PH_DX: begin
          held_dx = b;
          next_phase = PH_DY;
        end
        PH_DY: begin
          next_phase = PH_STATUS;
          div_eff = (speed_reg == 0) ? 1 : int'(speed_reg);
          wb = (int'(width_reg) > COORD_MAX) ? COORD_MAX : int'(width_reg);
          hb = (int'(height_reg) > COORD_MAX) ? COORD_MAX : int'(height_reg);
          // Signed division truncates toward zero.
          step_x = int'($signed(held_dx)) / div_eff;
          step_y = int'($signed(b)) / div_eff;
          nx = pos_x;
          ny = pos_y;
          if (!held_status[STATUS_X_OVF_BIT]) nx = nx + step_x;
          if (!held_status[STATUS_Y_OVF_BIT]) ny = ny - step_y;
          pos_x = clamp_axis(nx, wb);
          pos_y = clamp_axis(ny, hb);
          lin_full = longint'(pos_x) + longint'(width_reg) * longint'(pos_y);
          item.status = held_status;
          item.x      = COORD_W'(pos_x);
          item.y      = COORD_W'(pos_y);
          item.lin    = LIN_W'(lin_full);
          awaited.push_back(item);
        end
        default: begin
          held_status = b;
          next_phase = PH_DX;
        end
      endcase
    endfunction

    // Compare one cursor item from the block with the oldest prediction.
    function void check_cursor(cursor_item_t got);
      cursor_item_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected cursor item status=%0h x=%0d y=%0d lin=%0d",
                 $time, got.status, got.x, got.y, got.lin);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: button_status expected %0h actual %0h", $time, want.status, got.status);
        errors++;
      end
      if (got.x !== want.x) begin
        $display("%0t: cursor_x expected %0d actual %0d", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: cursor_y expected %0d actual %0d", $time, want.y, got.y);
        errors++;
      end
      if (got.lin !== want.lin) begin
        $display("%0t: linear_position expected %0d actual %0d", $time, want.lin, got.lin);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pmct_byte_if   byte_ch ();
  pmct_cursor_if cursor_ch ();

  cursor_tracker_sb tracker = new();

  // Traffic shaping shared by the driving processes.
  bit          quiet;
  int          rx_hold_cycles;
  int          rx_stall_left;
  int unsigned cycle_count;

  ps2_mouse_cursor_tracker_core dut (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .cursor_ch (cursor_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stall bursts, plus a long hold-off on request.
  initial begin
    cursor_ch.ready = 1'b0;
    rx_hold_cycles = 0;
    rx_stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        cursor_ch.ready = 1'b0;
        rx_hold_cycles--;
      end else if (rx_stall_left > 0) begin
        cursor_ch.ready = 1'b0;
        rx_stall_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        cursor_ch.ready = 1'b0;
        rx_stall_left = $urandom_range(1, 13) - 1;
      end else begin
        cursor_ch.ready = 1'b1;
      end
    end
  end

  // Check every cursor item the block hands over.
  always @(posedge clk) begin
    cursor_item_t got;
    if (!rst && cursor_ch.valid && cursor_ch.ready) begin
      got.status = cursor_ch.button_status;
      got.x      = cursor_ch.cursor_x;
      got.y      = cursor_ch.cursor_y;
      got.lin    = cursor_ch.linear_position;
      tracker.check_cursor(got);
    end
  end

  // Offer one mouse byte, with an occasional idle burst ahead of it.
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      repeat (gap) begin
        @(negedge clk);
        byte_ch.valid = 1'b0;
        byte_ch.rx_byte = BYTE_W'($urandom);
      end
    end
    @(negedge clk);
    byte_ch.valid = 1'b1;
    byte_ch.rx_byte = b;
    do @(posedge clk); while (!byte_ch.ready);
    tracker.note_byte(b);
  endtask

  task automatic push_packet(input logic [BYTE_W-1:0] status, input logic [BYTE_W-1:0] dx,
                             input logic [BYTE_W-1:0] dy);
    push_byte(status);
    push_byte(dx);
    push_byte(dy);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    tracker.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Stop offering bytes, wait for every predicted item, then let the core go quiet.
  task automatic settle();
    @(negedge clk);
    byte_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed packets with random content; some lone bytes shift the framing.
  // Drift mode pushes the cursor steadily toward the far corner.
  task automatic run_traffic(input int packets, input bit drift);
    logic [BYTE_W-1:0] status, dx, dy;
    for (int i = 0; i < packets; i++) begin
      if (!drift && $urandom_range(0, 9) == 0) begin
        push_byte(BYTE_W'($urandom));
      end
      status = BYTE_W'($urandom);
      if (drift) begin
        status[STATUS_X_OVF_BIT] = 1'b0;
        status[STATUS_Y_OVF_BIT] = 1'b0;
        dx = BYTE_W'($urandom_range(112, 127));
        dy = BYTE_W'($urandom_range(128, 144));
      end else begin
        if ($urandom_range(0, 2) != 0) status[STATUS_X_OVF_BIT] = 1'b0;
        if ($urandom_range(0, 2) != 0) status[STATUS_Y_OVF_BIT] = 1'b0;
        dx = BYTE_W'($urandom);
        dy = BYTE_W'($urandom);
      end
      push_packet(status, dx, dy);
    end
  endtask

  task automatic apply_config(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                              input logic [CFG_DATA_W-1:0] d);
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
    write_reg(CFG_SPEED_DIVISOR, d);
  endtask

  // Main sequence.
  initial begin
    rst = 1'b1;
    quiet = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SCREEN_WIDTH;
    cfg_data = '0;
    byte_ch.valid = 1'b0;
    byte_ch.rx_byte = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at reset settings: the dropped first byte, delta extremes,
    // clamping at zero and each overflow flag.
    push_byte(8'hA5);
    push_packet(8'h00, 8'h7F, 8'h80);
    push_packet(8'h30, 8'h80, 8'h7F);
    push_packet(8'h40, 8'h7F, 8'h81);
    push_packet(8'h80, 8'h10, 8'h7F);
    push_packet(8'hC0, 8'h7F, 8'h80);
    push_packet(8'hFF, 8'hFF, 8'hFF);
    push_packet(8'h08, 8'h01, 8'h01);
    push_packet(8'h07, 8'h00, 8'h00);
    settle();

    // Smallest legal settings.
    apply_config(13'd1, 13'd1, 13'd1);
    run_traffic(10, 1'b0);
    settle();

    // Largest legal settings.
    apply_config(13'd4096, 13'd4096, 13'd255);
    run_traffic(10, 1'b0);
    settle();

    // Long hold-off on the result side while bytes keep coming.
    apply_config(13'd640, 13'd480, 13'd2);
    rx_hold_cycles = 300;
    run_traffic(16, 1'b0);
    settle();

    // Bounds beyond range and a zero divisor; driving into the corner wraps
    // the linear position.
    apply_config(13'h1FFF, 13'h1FFF, 13'd0);
    run_traffic(40, 1'b1);
    settle();

    // Zero bounds pin both axes.
    apply_config(13'd0, 13'd0, 13'd3);
    run_traffic(10, 1'b0);
    settle();

    // Random legal settings with mostly small divisors.
    for (int p = 0; p < 3; p++) begin
      apply_config(CFG_DATA_W'($urandom_range(1, 4096)), CFG_DATA_W'($urandom_range(1, 4096)),
                   CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                           : $urandom_range(1, 8)));
      run_traffic(8, 1'b0);
      settle();
    end

    apply_config(13'd4097, 13'd300, 13'd1);
    run_traffic(10, 1'b0);
    settle();

    // Closing stretch with no idling on either side.
    quiet = 1'b1;
    apply_config(13'd1024, 13'd768, 13'd1);
    run_traffic(10, 1'b0);
    apply_config_pending_free: begin
      settle();
      apply_config(CFG_DATA_W'($urandom_range(1, 4096)), CFG_DATA_W'($urandom_range(1, 4096)),
                   CFG_DATA_W'($urandom_range(1, 4)));
      run_traffic(10, 1'b0);
    end

    // Drain and give the core time to show any stray item.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.pending() != 0) begin
      $display("%0t: %0d cursor items never arrived", $time, tracker.pending());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
